[rtl/core/bpsab_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap pixel store package
// Shared widths, command and register codes, and the structs that pass
// configuration, pixel location and byte-lane control between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsab_pkg;

    // Byte address width: enough for 511 rows of a 2044-byte stride
    localparam int ADDR_W    = 22;
    localparam int WORD_W    = ADDR_W - 2;
    localparam int NUM_LANES = 4;

    // Default frame size in bytes
    localparam int FRAME_BYTES_DEF = 262144;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_PIXEL = 2'd2;

    // Configuration reset values
    localparam logic [8:0] WIDTH_RST  = 9'd256;
    localparam logic [8:0] HEIGHT_RST = 9'd256;
    localparam logic [5:0] BPP_RST    = 6'd32;

    // Supported pixel depths
    localparam logic [5:0] DEPTH_24 = 6'd24;
    localparam logic [5:0] DEPTH_32 = 6'd32;

    // Command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_BLEND = 2'd2;

    typedef struct packed {
        logic [8:0] image_width;
        logic [8:0] image_height;
        logic [5:0] bits_per_pixel;
    } cfg_t;

    // Effective pixel coordinate and its access check
    typedef struct packed {
        logic       ok;
        logic [8:0] x;
        logic [8:0] y;
    } loc_t;

    // Per-lane control for one pixel access
    typedef struct packed {
        logic [NUM_LANES-1:0]             en;
        logic [1:0]                       offset;
        logic [NUM_LANES-1:0][WORD_W-1:0] word;
    } lanes_t;

endpackage

`default_nettype wire

[rtl/core/bpsab_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, read first: a registered read of the old contents
// while a write goes into the array. No reset: contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire  logic                                 clk,
    input  wire  logic                                 en,
    input  wire  logic                                 we,
    input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire  logic [WIDTH-1:0]                     wdata,
    output logic       [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Access the array; hold read data while disabled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/bpsab_locate.sv]
// ----------------------------------------------------------------------------
// Pixel locator
// Applies the row flip for writes and blends, then checks the coordinate
// against the image size and the pixel depth against the supported set.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsab_locate
    import bpsab_pkg::*;
(
    input  wire  cfg_t        cfg,
    input  wire  logic [1:0]  command,
    input  wire  logic [10:0] column,
    input  wire  logic [10:0] row,
    input  wire  logic        flip_rows,
    output loc_t              loc
);

    logic [11:0] y_in;
    logic [11:0] y_flip;
    logic [11:0] y_eff;
    logic        flip_on;
    logic        x_ok;
    logic        y_ok;
    logic        depth_ok;

    // Map the row for flipped writes and blends
    always_comb
    begin
        y_in    = {row[10], row};
        y_flip  = {3'b000, cfg.image_height} - 12'd1 - y_in;
        flip_on = flip_rows && (command == CMD_WRITE || command == CMD_BLEND);
        y_eff   = flip_on ? y_flip : y_in;
    end

    // Check coordinate and depth
    always_comb
    begin
        x_ok     = !column[10] && (column[9:0] < {1'b0, cfg.image_width});
        y_ok     = !y_eff[11] && (y_eff[10:0] < {2'b00, cfg.image_height});
        depth_ok = (cfg.bits_per_pixel == DEPTH_24) || (cfg.bits_per_pixel == DEPTH_32);
        loc.ok   = x_ok && y_ok && depth_ok;
        loc.x    = column[8:0];
        loc.y    = y_eff[8:0];
    end

endmodule

`default_nettype wire

[rtl/core/bpsab_lanes.sv]
// ----------------------------------------------------------------------------
// Byte-lane splitter
// Spreads the bytes of one pixel over the four byte lanes of the frame
// memory: word index per lane, and which lanes the pixel covers inside
// the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsab_lanes
    import bpsab_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire  logic [ADDR_W-1:0] byte_addr,
    input  wire  logic              is32,
    output lanes_t                  lanes
);

    // Place each pixel byte on its lane
    always_comb
    begin
        logic [1:0]        k;
        logic [ADDR_W-1:0] b;
        lanes.offset = byte_addr[1:0];
        for (int l = 0; l < NUM_LANES; l++)
        begin
            k             = 2'(l) - byte_addr[1:0];
            b             = byte_addr + ADDR_W'(k);
            lanes.word[l] = b[ADDR_W-1:2];
            lanes.en[l]   = (is32 || k != 2'd3)
                            && ({{(32-ADDR_W){1'b0}}, b} < 32'(FRAME_BYTES));
        end
    end

endmodule

`default_nettype wire

[rtl/core/bpsab_blend.sv]
// ----------------------------------------------------------------------------
// Pixel modify unit
// Gathers the stored pixel from the lane read data, forms the new pixel
// (plain write or alpha blend) and scatters it back onto the lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsab_blend
    import bpsab_pkg::*;
(
    input  wire  logic [1:0]                  command,
    input  wire  logic                        ok,
    input  wire  logic [31:0]                 pixel_value,
    input  wire  lanes_t                      lanes,
    input  wire  logic [NUM_LANES-1:0][7:0]   rdata,
    output logic       [NUM_LANES-1:0][7:0]   wdata,
    output logic       [NUM_LANES-1:0]        we,
    output logic       [31:0]                 read_data
);

    logic [NUM_LANES-1:0][7:0] dst;
    logic [31:0]               new_pix;
    logic [7:0]                alpha;
    logic                      do_write;

    // One channel: (src*a + (255-a)*dst) >> 8
    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
        logic [15:0] p;
        p = 16'(s) * 16'(a) + 16'(d) * 16'(8'hFF - a);
        return p[15:8];
    endfunction

    // Gather stored bytes in pixel order; uncovered bytes read as zero
    always_comb
    begin
        logic [1:0] ln;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            ln     = lanes.offset + 2'(k);
            dst[k] = lanes.en[ln] ? rdata[ln] : 8'h00;
        end
    end

    // Form the new pixel
    always_comb
    begin
        alpha = pixel_value[31:24];
        if (command == CMD_BLEND)
        begin
            new_pix = {8'h00,
                       mix(pixel_value[23:16], dst[2], alpha),
                       mix(pixel_value[15:8],  dst[1], alpha),
                       mix(pixel_value[7:0],   dst[0], alpha)};
        end
        else
        begin
            new_pix = pixel_value;
        end
        do_write  = ok && (command == CMD_WRITE || command == CMD_BLEND);
        read_data = (ok && command == CMD_READ) ? dst : 32'h0;
    end

    // Scatter the new pixel onto the lanes
    always_comb
    begin
        logic [1:0] k;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            k        = 2'(l) - lanes.offset;
            wdata[l] = new_pix[8*k +: 8];
            we[l]    = do_write && lanes.en[l];
        end
    end

endmodule

`default_nettype wire

[rtl/core/bitmap_pixel_store_with_alpha_blend_unit.sv]
// ----------------------------------------------------------------------------
// Bitmap pixel store with alpha blend
// Byte-addressed frame in four byte-lane RAMs, rows padded to 4 bytes.
// Reads, writes and alpha-blended writes of 24- and 32-bit pixels.
//
//   channel   direction  beat contents
//   s_axis    in         tdata: column, row, pixel_value; tuser: command, flip_rows
//   m_axis    out        tdata: read_data; tuser: in_range
//   cfg       in         cfg_index selects the register, cfg_data the value
//
// A pixel passes through the address multiply, the lane RAM read, then modify
// and write back through the same single RAM port. The next beat is accepted in
// the write-back cycle, so a new pixel is taken while the last one is written back.
// Reset clears the sequencer and the output register and loads the configuration
// defaults; frame memory is not cleared. A result waiting in the output register
// holds the block in write-back until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_pixel_store_with_alpha_blend_unit
    import bpsab_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  wire  logic                   clk,
    input  wire  logic                   rst_n,
    // Command stream
    input  wire  logic                   s_tvalid,
    output logic                         s_tready,
    input  wire  logic [55:0]            s_tdata,   // column[10:0], row[21:11],
                                                    // pixel_value[53:22], zero[55:54]
    input  wire  logic [2:0]             s_tuser,   // command[1:0], flip_rows[2]
    // Result stream
    output logic                         m_tvalid,
    input  wire  logic                   m_tready,
    output logic [31:0]                  m_tdata,   // read_data[31:0]
    output logic [0:0]                   m_tuser,   // in_range[0]
    // Configuration writes
    input  wire  logic                   cfg_valid,
    output logic                         cfg_ready,
    input  wire  logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LANE_DEPTH = (FRAME_BYTES + 3) / 4;
    localparam int LANE_AW    = LANE_DEPTH > 1 ? $clog2(LANE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_WB
    } state_t;

    state_t state_reg;
    state_t state_next;

    cfg_t cfg_reg;

    logic [1:0]        cmd_reg;
    logic [31:0]       val_reg;
    loc_t              loc_reg;
    loc_t              loc_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    lanes_t            lane_reg;
    lanes_t            lanes_now;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic        s_fire;
    logic        out_free;
    logic        wb_fire;
    logic        is32;
    logic [10:0] w3;
    logic [10:0] w3_pad;
    logic [10:0] stride;

    logic [NUM_LANES-1:0][7:0]         ram_rdata;
    logic [NUM_LANES-1:0][7:0]         ram_wdata;
    logic [NUM_LANES-1:0]              lane_we;
    logic [NUM_LANES-1:0][LANE_AW-1:0] ram_addr;
    logic                              ram_en;
    logic [31:0]                       read_data;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign wb_fire   = (state_reg == ST_WB) && out_free;
    assign s_tready  = (state_reg == ST_IDLE) || wb_fire;
    assign s_fire    = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width    <= WIDTH_RST;
            cfg_reg.image_height   <= HEIGHT_RST;
            cfg_reg.bits_per_pixel <= BPP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    cfg_reg.image_width    <= cfg_data;
                REG_IMAGE_HEIGHT:   cfg_reg.image_height   <= cfg_data;
                REG_BITS_PER_PIXEL: cfg_reg.bits_per_pixel <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    // Locate the incoming pixel
    bpsab_locate u_locate (
        .cfg       (cfg_reg),
        .command   (s_tuser[1:0]),
        .column    (s_tdata[10:0]),
        .row       (s_tdata[21:11]),
        .flip_rows (s_tuser[2]),
        .loc       (loc_next)
    );

    // Row stride in bytes and byte address of the pixel
    always_comb
    begin
        is32      = (cfg_reg.bits_per_pixel == DEPTH_32);
        w3        = {1'b0, cfg_reg.image_width, 1'b0} + {2'b00, cfg_reg.image_width};
        w3_pad    = w3 + 11'd3;
        stride    = is32 ? {cfg_reg.image_width, 2'b00} : {w3_pad[10:2], 2'b00};
        addr_next = ADDR_W'(loc_reg.y) * ADDR_W'(stride)
                    + (is32 ? ADDR_W'({loc_reg.x, 2'b00})
                            : ADDR_W'({loc_reg.x, 1'b0}) + ADDR_W'(loc_reg.x));
    end

    // Split the byte address over the lanes
    bpsab_lanes #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_lanes (
        .byte_addr (addr_reg),
        .is32      (is32),
        .lanes     (lanes_now)
    );

    // Modify the stored pixel
    bpsab_blend u_blend (
        .command     (cmd_reg),
        .ok          (loc_reg.ok),
        .pixel_value (val_reg),
        .lanes       (lane_reg),
        .rdata       (ram_rdata),
        .wdata       (ram_wdata),
        .we          (lane_we),
        .read_data   (read_data)
    );

    // Drive the lane RAM port: read in the read cycle, write in write-back
    always_comb
    begin
        ram_en = (state_reg == ST_READ) || wb_fire;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            ram_addr[l] = (state_reg == ST_READ) ? LANE_AW'(lanes_now.word[l])
                                                 : LANE_AW'(lane_reg.word[l]);
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        bpsab_ram #(
            .WIDTH (8),
            .DEPTH (LANE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .en    (ram_en),
            .we    (wb_fire && lane_we[g]),
            .addr  (ram_addr[g]),
            .wdata (ram_wdata[g]),
            .rdata (ram_rdata[g])
        );
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_WB;
            ST_WB:
            begin
                if (wb_fire)
                begin
                    state_next = s_fire ? ST_ADDR : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 32'h0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wb_fire)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= read_data;
                m_tuser_reg  <= loc_reg.ok;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Capture the beat, its address and its lane control
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg <= s_tuser[1:0];
            val_reg <= s_tdata[53:22];
            loc_reg <= loc_next;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= addr_next;
        end
        if (state_reg == ST_READ)
        begin
            lane_reg <= lanes_now;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire
